### design/cpm_pkg.sv
// Shared types, constants and register codes of the three-point colormap unit.
`default_nettype none

package cpm_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_W          = 16;
    localparam int CH_W            = 8;
    localparam int COLOR_W         = 3 * CH_W;
    localparam int PROD_W          = CH_W + FRAC_W;

    localparam logic [FRAC_W:0]   FRAC_ONE   = (FRAC_W + 1)'(1) << FRAC_W;
    localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_W - 1);

    localparam logic [63:0]        RST_LOW_VALUE  = 64'd0;
    localparam logic [63:0]        RST_MID_VALUE  = 64'd32768;
    localparam logic [63:0]        RST_HIGH_VALUE = 64'd65536;
    localparam logic [COLOR_W-1:0] RST_LOW_COLOR  = 24'h0000FF;
    localparam logic [COLOR_W-1:0] RST_MID_COLOR  = 24'h00FF00;
    localparam logic [COLOR_W-1:0] RST_HIGH_COLOR = 24'hFF0000;

    typedef enum logic [2:0] {
        REG_LOW_VALUE  = 3'd0,
        REG_MID_VALUE  = 3'd1,
        REG_HIGH_VALUE = 3'd2,
        REG_LOW_COLOR  = 3'd3,
        REG_MID_COLOR  = 3'd4,
        REG_HIGH_COLOR = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0] low;
        logic [COLOR_W-1:0] mid;
        logic [COLOR_W-1:0] high;
    } t_colors;

    // Control that travels with one sample down the pipeline.
    typedef struct packed {
        logic valid;
        logic range_err;
        logic lower;
        logic force_zero;
        logic force_one;
    } t_seg_ctrl;

endpackage

`default_nettype wire

### design/cpm_cfg_regs.sv
// Configuration register file of the three-point colormap unit, APB-style access.
`default_nettype none

module cpm_cfg_regs #(
    parameter int VALUE_WIDTH = cpm_pkg::VALUE_WIDTH_DEF,
    parameter int PDATA_W     = 32,
    parameter int ADDR_W      = 5
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_psel,
    input  wire logic                   i_penable,
    input  wire logic                   i_pwrite,
    input  wire logic [ADDR_W-1:0]      i_paddr,
    input  wire logic [PDATA_W-1:0]     i_pwdata,
    output logic      [PDATA_W-1:0]     o_prdata,
    output logic      [VALUE_WIDTH-1:0] o_low_value,
    output logic      [VALUE_WIDTH-1:0] o_mid_value,
    output logic      [VALUE_WIDTH-1:0] o_high_value,
    output cpm_pkg::t_colors            o_colors
);

    logic [VALUE_WIDTH-1:0] r_low_value, r_mid_value, r_high_value;
    cpm_pkg::t_colors       r_colors;
    cpm_pkg::t_reg_idx      w_idx;
    logic                   w_wr;

    // The register index sits in the three address bits above the word offset.
    assign w_idx = cpm_pkg::t_reg_idx'(i_paddr[ADDR_W-1:ADDR_W-3]);
    assign w_wr  = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_value    <= VALUE_WIDTH'(cpm_pkg::RST_LOW_VALUE);
            r_mid_value    <= VALUE_WIDTH'(cpm_pkg::RST_MID_VALUE);
            r_high_value   <= VALUE_WIDTH'(cpm_pkg::RST_HIGH_VALUE);
            r_colors.low   <= cpm_pkg::RST_LOW_COLOR;
            r_colors.mid   <= cpm_pkg::RST_MID_COLOR;
            r_colors.high  <= cpm_pkg::RST_HIGH_COLOR;
        end else if (w_wr) begin
            case (w_idx)
                cpm_pkg::REG_LOW_VALUE:  r_low_value   <= i_pwdata[VALUE_WIDTH-1:0];
                cpm_pkg::REG_MID_VALUE:  r_mid_value   <= i_pwdata[VALUE_WIDTH-1:0];
                cpm_pkg::REG_HIGH_VALUE: r_high_value  <= i_pwdata[VALUE_WIDTH-1:0];
                cpm_pkg::REG_LOW_COLOR:  r_colors.low  <= i_pwdata[cpm_pkg::COLOR_W-1:0];
                cpm_pkg::REG_MID_COLOR:  r_colors.mid  <= i_pwdata[cpm_pkg::COLOR_W-1:0];
                cpm_pkg::REG_HIGH_COLOR: r_colors.high <= i_pwdata[cpm_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            cpm_pkg::REG_LOW_VALUE:  o_prdata = PDATA_W'(r_low_value);
            cpm_pkg::REG_MID_VALUE:  o_prdata = PDATA_W'(r_mid_value);
            cpm_pkg::REG_HIGH_VALUE: o_prdata = PDATA_W'(r_high_value);
            cpm_pkg::REG_LOW_COLOR:  o_prdata = PDATA_W'(r_colors.low);
            cpm_pkg::REG_MID_COLOR:  o_prdata = PDATA_W'(r_colors.mid);
            cpm_pkg::REG_HIGH_COLOR: o_prdata = PDATA_W'(r_colors.high);
            default:                 o_prdata = '0;
        endcase
    end

    assign o_low_value  = r_low_value;
    assign o_mid_value  = r_mid_value;
    assign o_high_value = r_high_value;
    assign o_colors     = r_colors;

endmodule

`default_nettype wire

### design/cpm_front.sv
// Front stages: order keys, range check, segment choice, offset and width.
`default_nettype none

module cpm_front #(
    parameter int VALUE_WIDTH = cpm_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [VALUE_WIDTH-1:0] i_low_value,
    input  wire logic [VALUE_WIDTH-1:0] i_mid_value,
    input  wire logic [VALUE_WIDTH-1:0] i_high_value,
    output cpm_pkg::t_seg_ctrl          o_ctrl,
    output logic      [VALUE_WIDTH-1:0] o_offset,
    output logic      [VALUE_WIDTH-1:0] o_width
);

    // Flipping the sign bit turns two's complement order into unsigned order.
    localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [VALUE_WIDTH-1:0] w_klo, w_kmid, w_khi, w_kv;
    logic [VALUE_WIDTH-1:0] w_start, w_end;
    cpm_pkg::t_seg_ctrl     w_ctrl;

    logic                   r_a_valid, r_a_lower, r_a_err;
    logic [VALUE_WIDTH-1:0] r_a_key;
    cpm_pkg::t_seg_ctrl     r_b_ctrl;
    logic [VALUE_WIDTH-1:0] r_b_offset, r_b_width;

    assign w_klo  = i_low_value ^ SIGN_BIT;
    assign w_kmid = i_mid_value ^ SIGN_BIT;
    assign w_khi  = i_high_value ^ SIGN_BIT;
    assign w_kv   = i_value ^ SIGN_BIT;

    // Stage A: segment choice and range check.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_key   <= w_kv;
            r_a_lower <= (w_kv < w_kmid);
            r_a_err   <= (w_kmid < w_klo) || (w_khi < w_kmid);
        end
    end

    // Stage B: segment ends, clamp decisions, offset and width for the divider.
    assign w_start = r_a_lower ? w_klo : w_kmid;
    assign w_end   = r_a_lower ? w_kmid : w_khi;

    always_comb begin
        w_ctrl.valid      = r_a_valid;
        w_ctrl.range_err  = r_a_err;
        w_ctrl.lower      = r_a_lower;
        w_ctrl.force_zero = (w_end == w_start) || (r_a_key <= w_start);
        w_ctrl.force_one  = (r_a_key >= w_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctrl <= '0;
        end else if (i_en) begin
            r_b_ctrl <= w_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_offset <= r_a_key - w_start;
            r_b_width  <= w_end - w_start;
        end
    end

    assign o_ctrl   = r_b_ctrl;
    assign o_offset = r_b_offset;
    assign o_width  = r_b_width;

endmodule

`default_nettype wire

### design/cpm_div_step.sv
// One restoring-division stage: produces one quotient bit of the blend factor.
`default_nettype none

module cpm_div_step #(
    parameter int VALUE_WIDTH = cpm_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire cpm_pkg::t_seg_ctrl          i_ctrl,
    input  wire logic [VALUE_WIDTH-1:0]      i_rem,
    input  wire logic [VALUE_WIDTH-1:0]      i_width,
    input  wire logic [cpm_pkg::FRAC_W-1:0]  i_quot,
    output cpm_pkg::t_seg_ctrl               o_ctrl,
    output logic      [VALUE_WIDTH-1:0]      o_rem,
    output logic      [VALUE_WIDTH-1:0]      o_width,
    output logic      [cpm_pkg::FRAC_W-1:0]  o_quot
);

    logic [VALUE_WIDTH:0]           w_shift, w_diff;
    logic                           w_ge;
    cpm_pkg::t_seg_ctrl             r_ctrl;
    logic [VALUE_WIDTH-1:0]         r_rem, r_width;
    logic [cpm_pkg::FRAC_W-1:0]     r_quot;

    // The shifted remainder is one bit wider so its top bit is never lost.
    assign w_shift = {i_rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, i_width};
    assign w_ge    = (w_shift >= {1'b0, i_width});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= w_ge ? w_diff[VALUE_WIDTH-1:0] : w_shift[VALUE_WIDTH-1:0];
            r_width <= i_width;
            r_quot  <= {i_quot[cpm_pkg::FRAC_W-2:0], w_ge};
        end
    end

    assign o_ctrl  = r_ctrl;
    assign o_rem   = r_rem;
    assign o_width = r_width;
    assign o_quot  = r_quot;

endmodule

`default_nettype wire

### design/cpm_blend.sv
// Blend stage: final factor, per-channel products, and rounded channel sums.
`default_nettype none

module cpm_blend (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire cpm_pkg::t_seg_ctrl          i_ctrl,
    input  wire logic [cpm_pkg::FRAC_W-1:0]  i_quot,
    input  wire cpm_pkg::t_colors            i_colors,
    output logic                             o_valid,
    output logic                             o_range_err,
    output logic      [cpm_pkg::COLOR_W-1:0] o_rgb
);

    localparam int CW = cpm_pkg::CH_W;
    localparam int PW = cpm_pkg::PROD_W;

    logic [cpm_pkg::FRAC_W:0]   w_frac, w_inv;
    logic [cpm_pkg::COLOR_W-1:0] w_ca, w_cb;
    logic                       r_valid, r_err;
    logic [PW-1:0]              r_pa [0:2];
    logic [PW-1:0]              r_pb [0:2];

    always_comb begin
        if (i_ctrl.force_zero) begin
            w_frac = '0;
        end else if (i_ctrl.force_one) begin
            w_frac = cpm_pkg::FRAC_ONE;
        end else begin
            w_frac = {1'b0, i_quot};
        end
    end

    assign w_inv = cpm_pkg::FRAC_ONE - w_frac;
    assign w_ca  = i_ctrl.lower ? i_colors.low : i_colors.mid;
    assign w_cb  = i_ctrl.lower ? i_colors.mid : i_colors.high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_err <= i_ctrl.range_err;
        end
    end

    // Lane 0 is blue, lane 1 green, lane 2 red, as in the packed color.
    for (genvar c = 0; c < 3; c++) begin : g_lane
        logic [PW:0] w_pa, w_pb, w_sum;

        assign w_pa = (PW + 1)'(w_ca[c*CW +: CW]) * (PW + 1)'(w_inv);
        assign w_pb = (PW + 1)'(w_cb[c*CW +: CW]) * (PW + 1)'(w_frac);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa[c] <= w_pa[PW-1:0];
                r_pb[c] <= w_pb[PW-1:0];
            end
        end

        assign w_sum = {1'b0, r_pa[c]} + {1'b0, r_pb[c]} + cpm_pkg::ROUND_HALF;
        assign o_rgb[c*CW +: CW] = r_err ? '0 : w_sum[PW-1:cpm_pkg::FRAC_W];
    end

    assign o_valid     = r_valid;
    assign o_range_err = r_err;

endmodule

`default_nettype wire

### design/three_point_colormap_unit.sv
// Top level of the three-point colormap unit: pipeline, output buffer, register port.
`default_nettype none

// Maps one signed Q16.16 field sample per transfer to an RGB pixel along a
// three-stop linear gradient. The unit accepts one sample every clock cycle
// while the skid register is empty. A sample passes from the input transfer
// to the output transfer through two front stages (order keys, range check,
// segment choice, offset and width), sixteen divider stages that each resolve
// one bit of the Q0.16 blend factor, one product stage, and the output
// register. Stalls on the output side are absorbed by an output register plus
// a one-entry skid register, so the input side keeps accepting samples while a
// finished pixel waits in the output register. o_s_tready depends only on
// registered state. The six configuration registers are written through the
// APB-style port, which is always ready. They feed the pipeline directly, so
// they must only be written while no sample is in flight. When middle_value
// is below low_value or high_value is below middle_value, every pixel comes
// out black with the range-error flag set in tuser.
module three_point_colormap_unit #(
    parameter int VALUE_WIDTH = cpm_pkg::VALUE_WIDTH_DEF,
    localparam int DATA_W     = ((VALUE_WIDTH + 7) / 8) * 8,
    localparam int PDATA_W    = (VALUE_WIDTH > 32) ? 64 : 32,
    localparam int ADDR_W     = (VALUE_WIDTH > 32) ? 6 : 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Sample input.
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [DATA_W-1:0]    i_s_tdata,   // field_value, zero padded
    // Pixel output.
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [cpm_pkg::COLOR_W-1:0] o_m_tdata, // red [7:0], green [15:8], blue [23:16]
    output logic [0:0]                o_m_tuser,   // range_error [0]
    // Configuration port.
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [ADDR_W-1:0]    paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready
);

    localparam int FW      = cpm_pkg::FRAC_W;
    localparam int CW      = cpm_pkg::CH_W;

    logic [VALUE_WIDTH-1:0] w_low_value, w_mid_value, w_high_value;
    cpm_pkg::t_colors       w_colors;

    // The whole pipeline advances together; it only holds when the skid
    // register is occupied, so the enable never depends on an input port.
    logic w_en;

    cpm_pkg::t_seg_ctrl     w_ctrl [0:FW];
    logic [VALUE_WIDTH-1:0] w_rem  [0:FW];
    logic [VALUE_WIDTH-1:0] w_wid  [0:FW];
    logic [FW-1:0]          w_quot [0:FW];

    logic                        w_pix_valid, w_pix_err;
    logic [cpm_pkg::COLOR_W-1:0] w_pix_rgb;

    logic                        r_out_valid, n_out_valid;
    logic                        r_out_err, n_out_err;
    logic [cpm_pkg::COLOR_W-1:0] r_out_rgb, n_out_rgb;
    logic                        r_skid_valid, n_skid_valid;
    logic                        r_skid_err, n_skid_err;
    logic [cpm_pkg::COLOR_W-1:0] r_skid_rgb, n_skid_rgb;
    logic                        w_take;

    assign pready = 1'b1;

    cpm_cfg_regs #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .PDATA_W     (PDATA_W),
        .ADDR_W      (ADDR_W)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_prdata     (prdata),
        .o_low_value  (w_low_value),
        .o_mid_value  (w_mid_value),
        .o_high_value (w_high_value),
        .o_colors     (w_colors)
    );

    assign w_en       = ~r_skid_valid;
    assign o_s_tready = w_en;

    cpm_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (i_s_tvalid),
        .i_value      (i_s_tdata[VALUE_WIDTH-1:0]),
        .i_low_value  (w_low_value),
        .i_mid_value  (w_mid_value),
        .i_high_value (w_high_value),
        .o_ctrl       (w_ctrl[0]),
        .o_offset     (w_rem[0]),
        .o_width      (w_wid[0])
    );

    assign w_quot[0] = '0;

    // One quotient bit per stage; the remainder stays below the width when the sample lies inside its segment.
    for (genvar s = 0; s < FW; s++) begin : g_div
        cpm_div_step #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctrl  (w_ctrl[s]),
            .i_rem   (w_rem[s]),
            .i_width (w_wid[s]),
            .i_quot  (w_quot[s]),
            .o_ctrl  (w_ctrl[s+1]),
            .o_rem   (w_rem[s+1]),
            .o_width (w_wid[s+1]),
            .o_quot  (w_quot[s+1])
        );
    end

    cpm_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_ctrl      (w_ctrl[FW]),
        .i_quot      (w_quot[FW]),
        .i_colors    (w_colors),
        .o_valid     (w_pix_valid),
        .o_range_err (w_pix_err),
        .o_rgb       (w_pix_rgb)
    );

    // Output register with a skid entry behind it. A pixel leaving the
    // pipeline goes straight to the output register when that one is free or
    // being taken, and into the skid entry otherwise; the full skid entry
    // then holds the pipeline until the output register drains it.
    assign w_take = ~r_out_valid | i_m_tready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_err    = r_out_err;
        n_out_rgb    = r_out_rgb;
        n_skid_valid = r_skid_valid;
        n_skid_err   = r_skid_err;
        n_skid_rgb   = r_skid_rgb;
        if (r_skid_valid) begin
            if (w_take) begin
                n_out_valid  = 1'b1;
                n_out_err    = r_skid_err;
                n_out_rgb    = r_skid_rgb;
                n_skid_valid = 1'b0;
            end
        end else if (w_pix_valid) begin
            if (w_take) begin
                n_out_valid = 1'b1;
                n_out_err   = w_pix_err;
                n_out_rgb   = w_pix_rgb;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_err   = w_pix_err;
                n_skid_rgb   = w_pix_rgb;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_err  <= n_out_err;
        r_out_rgb  <= n_out_rgb;
        r_skid_err <= n_skid_err;
        r_skid_rgb <= n_skid_rgb;
    end

    // The internal color is packed red high; the stream carries red low.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_rgb[CW-1:0], r_out_rgb[2*CW-1:CW], r_out_rgb[3*CW-1:2*CW]};
    assign o_m_tuser  = r_out_err;

endmodule

`default_nettype wire

### design/cpm_checker.sv
// Port-level assertions for the three-point colormap unit and their bind.
`default_nettype none

module cpm_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_s_tready,
    input wire logic                        o_m_tvalid,
    input wire logic                        i_m_tready,
    input wire logic [cpm_pkg::COLOR_W-1:0] o_m_tdata,
    input wire logic [0:0]                  o_m_tuser,
    input wire logic                        pready
);

    // A stalled pixel stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("output pixel changed while stalled");

    // A pixel flagged as a range error is black.
    a_err_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("range error pixel is not black");

    // The input side is only held back when a finished pixel is waiting.
    a_hold_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid)
        else $error("input stalled with empty output");

    // Reset leaves no pixel pending and the input side open.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && o_s_tready && pready))
        else $error("pipeline not cleared by reset");

endmodule

bind three_point_colormap_unit cpm_checker u_cpm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .pready     (pready)
);

`default_nettype wire
